/* hw/rtl/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg - shared types and constants of the heightmap sampler
// Command codes, register map, the queue entry and the config bundle.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_HEIGHT = 2'd1;
  localparam logic [1:0] CMD_NORMAL = 2'd2;

  localparam logic [2:0] REG_INV_SCALE_X = 3'd0;
  localparam logic [2:0] REG_INV_SCALE_Z = 3'd1;
  localparam logic [2:0] REG_SCALE_X     = 3'd2;
  localparam logic [2:0] REG_SCALE_Y     = 3'd3;
  localparam logic [2:0] REG_SCALE_Z     = 3'd4;
  localparam logic [2:0] REG_MAP_WIDTH   = 3'd5;
  localparam logic [2:0] REG_MAP_LENGTH  = 3'd6;
  localparam logic [2:0] REG_CORNER      = 3'd7;

  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [47:0] NORMAL_UP = 48'd65536;

  typedef enum logic [1:0] {
    K_NONE,
    K_WRITE,
    K_HEIGHT,
    K_NORMAL
  } kind_e;

  // width/length are already limited to the store size
  typedef struct packed {
    logic [15:0] inv_scale_x;
    logic [15:0] inv_scale_z;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
    logic [15:0] scale_z;
    logic [10:0] width;
    logic [10:0] length;
    logic        corner;
  } cfg_t;

  // col/row "a" is the base texel, "b" the neighbor; *_same means b == a
  typedef struct packed {
    kind_e       kind;
    logic        oor;
    logic [9:0]  col_a;
    logic [9:0]  col_b;
    logic [9:0]  row_a;
    logic [9:0]  row_b;
    logic        col_same;
    logic        row_same;
    logic [15:0] px;
    logic [15:0] pz;
    logic        rev;
    logic [7:0]  texel;
  } entry_t;

endpackage

/* hw/rtl/hbs_front.sv */
// ----------------------------------------------------------------------------
// hbs_front - input stage and command classifier
// Scales world coordinates, checks bounds and builds texel addresses.
// ----------------------------------------------------------------------------
module hbs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hbs_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic signed [23:0]  world_x_i,
  input  logic signed [23:0]  world_z_i,
  input  logic                reverse_quad_i,
  input  logic signed [10:0]  grid_x_i,
  input  logic signed [10:0]  grid_z_i,
  input  logic [7:0]          texel_value_i,
  input  logic                full_i,
  output logic                push_o,
  output hbs_pkg::entry_t     entry_o
);

  logic               valid_q, valid_d;
  logic signed [40:0] fx_q, fz_q;
  logic [1:0]         cmd_q;
  logic               rev_q;
  logic signed [10:0] gx_q, gz_q;
  logic [7:0]         tv_q;
  logic               accept;

  logic [24:0] xi, zi;
  logic [10:0] h_xn, h_zn, n_xn, n_zn;
  logic        h_oor, g_oor;

  assign in_stall_o = valid_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fx_q  <= world_x_i * $signed({1'b0, cfg_i.inv_scale_x});
      fz_q  <= world_z_i * $signed({1'b0, cfg_i.inv_scale_z});
      cmd_q <= command_i;
      rev_q <= reverse_quad_i;
      gx_q  <= grid_x_i;
      gz_q  <= grid_z_i;
      tv_q  <= texel_value_i;
    end
  end

  // cell index and bounds
  assign xi    = fx_q[40:16];
  assign zi    = fz_q[40:16];
  assign h_oor = fx_q[40] | fz_q[40] | (xi >= 25'(cfg_i.width)) | (zi >= 25'(cfg_i.length));
  assign g_oor = gx_q[10] | gz_q[10] | ({1'b0, gx_q[9:0]} >= cfg_i.width)
               | ({1'b0, gz_q[9:0]} >= cfg_i.length);
  assign h_xn  = {1'b0, xi[9:0]} + 11'd1;
  assign h_zn  = {1'b0, zi[9:0]} + 11'd1;
  assign n_xn  = {1'b0, gx_q[9:0]} + 11'd1;
  assign n_zn  = {1'b0, gz_q[9:0]} + 11'd1;

  always_comb begin
    entry_o          = '0;
    entry_o.rev      = rev_q;
    entry_o.texel    = tv_q;
    entry_o.px       = fx_q[15:0];
    entry_o.pz       = fz_q[15:0];
    case (cmd_q)
      hbs_pkg::CMD_WRITE: begin
        entry_o.kind  = hbs_pkg::K_WRITE;
        entry_o.oor   = g_oor;
        entry_o.col_a = gx_q[9:0];
        // file rows are stored upside down
        entry_o.row_a = 10'(cfg_i.length - 11'd1 - gz_q);
        entry_o.col_b = entry_o.col_a;
        entry_o.row_b = entry_o.row_a;
      end
      hbs_pkg::CMD_HEIGHT: begin
        entry_o.kind     = hbs_pkg::K_HEIGHT;
        entry_o.oor      = h_oor;
        entry_o.col_a    = xi[9:0];
        entry_o.row_a    = zi[9:0];
        // right and top neighbors clamp at the far edge
        entry_o.col_same = ~(h_xn < cfg_i.width);
        entry_o.row_same = ~(h_zn < cfg_i.length);
        entry_o.col_b    = entry_o.col_same ? xi[9:0] : h_xn[9:0];
        entry_o.row_b    = entry_o.row_same ? zi[9:0] : h_zn[9:0];
      end
      hbs_pkg::CMD_NORMAL: begin
        entry_o.kind  = hbs_pkg::K_NORMAL;
        entry_o.oor   = g_oor;
        entry_o.col_a = gx_q[9:0];
        entry_o.row_a = gz_q[9:0];
        // step back at the last column/row; a one-wide map uses the point
        if (n_xn < cfg_i.width) begin
          entry_o.col_b = n_xn[9:0];
        end else if (gx_q[9:0] != 10'd0) begin
          entry_o.col_b = gx_q[9:0] - 10'd1;
        end else begin
          entry_o.col_b    = gx_q[9:0];
          entry_o.col_same = 1'b1;
        end
        if (n_zn < cfg_i.length) begin
          entry_o.row_b = n_zn[9:0];
        end else if (gz_q[9:0] != 10'd0) begin
          entry_o.row_b = gz_q[9:0] - 10'd1;
        end else begin
          entry_o.row_b    = gz_q[9:0];
          entry_o.row_same = 1'b1;
        end
      end
      default: begin
        entry_o.kind = hbs_pkg::K_NONE;
      end
    endcase
  end

endmodule

/* hw/rtl/hbs_queue.sv */
// ----------------------------------------------------------------------------
// hbs_queue - small FIFO between classifier and datapath
// Holds classified beats so front and back stall independently.
// ----------------------------------------------------------------------------
module hbs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hbs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output hbs_pkg::entry_t head_o
);

  hbs_pkg::entry_t                 slot_q [hbs_pkg::QUEUE_DEPTH];
  logic [hbs_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [hbs_pkg::QCNT_W-1:0]      count_q, count_d;

  assign full_o  = (count_q == hbs_pkg::QCNT_W'(hbs_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + hbs_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - hbs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= wr_q + hbs_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + hbs_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + hbs_pkg::QCNT_W'(1)))
    else $error("queue count did not advance");

endmodule

/* hw/rtl/hbs_back.sv */
// ----------------------------------------------------------------------------
// hbs_back - banked texel store and interpolation datapath
// Four parity banks give a 2x2 texel quad per beat; three-stage pipeline.
// ----------------------------------------------------------------------------
module hbs_back #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_LENGTH = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbs_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  hbs_pkg::entry_t    head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] height_o,
  output logic signed [47:0] normal_x_o,
  output logic signed [47:0] normal_y_o,
  output logic signed [47:0] normal_z_o,
  output logic               out_of_range_o
);

  localparam int unsigned RH    = (MAX_LENGTH + 1) / 2;
  localparam int unsigned CH    = (MAX_WIDTH + 1) / 2;
  localparam int unsigned DEPTH = RH * CH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic adv;
  assign adv   = ~(out_valid_o & out_stall_i);
  assign pop_o = adv & ~empty_i;

  // ---- stage 1: bank access
  logic            b1_valid_q;
  hbs_pkg::entry_t b1_q;
  logic [7:0]      rdata_q [4];
  logic            wr_hit;
  logic [AW-1:0]   wr_addr;

  assign wr_hit  = pop_o & (head_i.kind == hbs_pkg::K_WRITE) & ~head_i.oor;
  assign wr_addr = AW'(head_i.row_a[9:1]) * AW'(CH) + AW'(head_i.col_a[9:1]);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int PR = b / 2;
    localparam int PC = b % 2;
    logic [7:0]    mem [DEPTH];
    logic [9:0]    rrow, rcol;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    assign rrow    = (head_i.row_a[0] == PR[0]) ? head_i.row_a : head_i.row_b;
    assign rcol    = (head_i.col_a[0] == PC[0]) ? head_i.col_a : head_i.col_b;
    assign rd_addr = AW'(rrow[9:1]) * AW'(CH) + AW'(rcol[9:1]);
    assign wr_en   = wr_hit & (head_i.row_a[0] == PR[0]) & (head_i.col_a[0] == PC[0]);

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[wr_addr] <= head_i.texel;
      end
      if (adv) begin
        rdata_q[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_q <= head_i;
    end
  end

  // ---- stage 1 -> 2: quad select, corner estimate, first blend
  logic       rpa, rpb, cpa, cpb;
  logic [7:0] t_bl, t_br, t_tl, t_tr;
  logic signed [9:0]  bl, br, tl, tr;
  logic signed [10:0] d_top, d_bot;
  logic signed [8:0]  dnx, dnz;
  logic signed [28:0] top_d, bot_d;
  logic signed [25:0] dx_d, dz_d;

  assign rpa = b1_q.row_a[0];
  assign cpa = b1_q.col_a[0];
  assign rpb = b1_q.row_same ? b1_q.row_a[0] : b1_q.row_b[0];
  assign cpb = b1_q.col_same ? b1_q.col_a[0] : b1_q.col_b[0];
  assign t_bl = rdata_q[{rpa, cpa}];
  assign t_br = rdata_q[{rpa, cpb}];
  assign t_tl = rdata_q[{rpb, cpa}];
  assign t_tr = rdata_q[{rpb, cpb}];

  always_comb begin
    bl = $signed({2'b00, t_bl});
    br = $signed({2'b00, t_br});
    tl = $signed({2'b00, t_tl});
    tr = $signed({2'b00, t_tr});
    if (cfg_i.corner) begin
      if (b1_q.rev) begin
        if (b1_q.pz >= b1_q.px) begin
          br = bl + tr - tl;
        end else begin
          tl = tr + bl - br;
        end
      end else begin
        if (({1'b0, b1_q.px} + {1'b0, b1_q.pz}) < 17'h10000) begin
          tr = tl + br - bl;
        end else begin
          bl = tl + br - tr;
        end
      end
    end
  end

  assign d_top = 11'(tr) - 11'(tl);
  assign d_bot = 11'(br) - 11'(bl);
  assign top_d = {{3{tl[9]}}, tl, 16'h0000} + 29'(d_top * $signed({1'b0, b1_q.px}));
  assign bot_d = {{3{bl[9]}}, bl, 16'h0000} + 29'(d_bot * $signed({1'b0, b1_q.px}));
  assign dnx   = $signed({1'b0, t_br}) - $signed({1'b0, t_bl});
  assign dnz   = $signed({1'b0, t_tl}) - $signed({1'b0, t_bl});
  assign dx_d  = dnx * $signed({1'b0, cfg_i.scale_y});
  assign dz_d  = dnz * $signed({1'b0, cfg_i.scale_y});

  logic               b2_valid_q;
  hbs_pkg::kind_e     b2_kind_q;
  logic               b2_oor_q;
  logic signed [28:0] top_q, bot_q;
  logic [15:0]        b2_pz_q;
  logic signed [25:0] dx_q, dz_q;
  logic [31:0]        sxz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else if (adv) begin
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b2_kind_q <= b1_q.kind;
      b2_oor_q  <= b1_q.oor;
      top_q     <= top_d;
      bot_q     <= bot_d;
      b2_pz_q   <= b1_q.pz;
      dx_q      <= dx_d;
      dz_q      <= dz_d;
      sxz_q     <= cfg_i.scale_x * cfg_i.scale_z;
    end
  end

  // ---- stage 2 -> 3: second blend, rounding, cross product
  logic signed [29:0] d_vert;
  logic signed [47:0] h_sum, h_rnd;
  logic signed [42:0] px_n, pz_n;
  logic signed [17:0] height_d;
  logic signed [47:0] nx_d, ny_d, nz_d;

  assign d_vert = 30'(top_q) - 30'(bot_q);
  assign h_sum  = {{3{bot_q[28]}}, bot_q, 16'h0000}
                + 48'(d_vert * $signed({1'b0, b2_pz_q}));
  assign h_rnd  = h_sum + 48'sh80_0000;
  assign px_n   = $signed({1'b0, cfg_i.scale_z}) * dx_q;
  assign pz_n   = $signed({1'b0, cfg_i.scale_x}) * dz_q;

  always_comb begin
    height_d = '0;
    nx_d     = '0;
    ny_d     = '0;
    nz_d     = '0;
    case (b2_kind_q)
      hbs_pkg::K_HEIGHT: begin
        if (!b2_oor_q) begin
          height_d = h_rnd[41:24];
        end
      end
      hbs_pkg::K_NORMAL: begin
        if (b2_oor_q) begin
          ny_d = hbs_pkg::NORMAL_UP;
        end else begin
          nx_d = -48'(px_n);
          ny_d = {16'h0000, sxz_q};
          nz_d = -48'(pz_n);
        end
      end
      default: begin
        height_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      height_o       <= height_d;
      normal_x_o     <= nx_d;
      normal_y_o     <= ny_d;
      normal_z_o     <= nz_d;
      out_of_range_o <= b2_oor_q & (b2_kind_q != hbs_pkg::K_NONE);
    end
  end

endmodule

/* hw/rtl/heightmap_bilinear_sampler.sv */
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler - 8-bit heightmap store with bilinear sampling
// Texel writes, height queries and normal queries over one command channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command beat: a texel
//   write, a height query at world x,z, or a normal query at a grid point.
//   Every beat, including writes and unknown commands, yields exactly one
//   result beat on the output channel (out_valid_o / out_stall_i), in order.
//   One beat per cycle is sustained while the receiver does not stall. The
//   path runs through the input multiply stage, the classifier queue, the
//   registered bank read and two blend multiply stages. The store is four
//   parity banks (row/column LSB), so the 2x2 texel quad of a height query
//   is read in one bank access.
//   When the receiver stalls, the datapath holds and the 4-entry queue
//   absorbs beats until full; then in_stall_o rises.
//   Reset clears control state and loads register defaults (scales 1.0,
//   map 512x512, corner estimate off). Texel contents are undefined until
//   written. Configure over APB only while the block is idle.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_LENGTH = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // command channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic signed [23:0]          world_x_i,
  input  logic signed [23:0]          world_z_i,
  input  logic                        reverse_quad_i,
  input  logic signed [10:0]          grid_x_i,
  input  logic signed [10:0]          grid_z_i,
  input  logic [7:0]                  texel_value_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [17:0]          height_o,
  output logic signed [47:0]          normal_x_o,
  output logic signed [47:0]          normal_y_o,
  output logic signed [47:0]          normal_z_o,
  output logic                        out_of_range_o
);

  // register file
  logic [15:0] inv_x_q, inv_z_q, sx_q, sy_q, sz_q;
  logic [10:0] width_q, length_q;
  logic        corner_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q  <= 16'd256;
      inv_z_q  <= 16'd256;
      sx_q     <= 16'd256;
      sy_q     <= 16'd256;
      sz_q     <= 16'd256;
      width_q  <= 11'd512;
      length_q <= 11'd512;
      corner_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        hbs_pkg::REG_INV_SCALE_X: inv_x_q  <= pwdata[15:0];
        hbs_pkg::REG_INV_SCALE_Z: inv_z_q  <= pwdata[15:0];
        hbs_pkg::REG_SCALE_X:     sx_q     <= pwdata[15:0];
        hbs_pkg::REG_SCALE_Y:     sy_q     <= pwdata[15:0];
        hbs_pkg::REG_SCALE_Z:     sz_q     <= pwdata[15:0];
        hbs_pkg::REG_MAP_WIDTH:   width_q  <= pwdata[10:0];
        hbs_pkg::REG_MAP_LENGTH:  length_q <= pwdata[10:0];
        hbs_pkg::REG_CORNER:      corner_q <= pwdata[0];
        default:                  corner_q <= corner_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hbs_pkg::REG_INV_SCALE_X: prdata = {16'h0, inv_x_q};
      hbs_pkg::REG_INV_SCALE_Z: prdata = {16'h0, inv_z_q};
      hbs_pkg::REG_SCALE_X:     prdata = {16'h0, sx_q};
      hbs_pkg::REG_SCALE_Y:     prdata = {16'h0, sy_q};
      hbs_pkg::REG_SCALE_Z:     prdata = {16'h0, sz_q};
      hbs_pkg::REG_MAP_WIDTH:   prdata = {21'h0, width_q};
      hbs_pkg::REG_MAP_LENGTH:  prdata = {21'h0, length_q};
      hbs_pkg::REG_CORNER:      prdata = {31'h0, corner_q};
      default:                  prdata = '0;
    endcase
  end

  // map size in use never exceeds the store
  hbs_pkg::cfg_t cfg;
  always_comb begin
    cfg.inv_scale_x = inv_x_q;
    cfg.inv_scale_z = inv_z_q;
    cfg.scale_x     = sx_q;
    cfg.scale_y     = sy_q;
    cfg.scale_z     = sz_q;
    cfg.width       = (width_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_q;
    cfg.length      = (length_q > 11'(MAX_LENGTH)) ? 11'(MAX_LENGTH) : length_q;
    cfg.corner      = corner_q;
  end

  logic            q_push, q_full, q_pop, q_empty;
  hbs_pkg::entry_t q_in, q_head;

  hbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .world_x_i      (world_x_i),
    .world_z_i      (world_z_i),
    .reverse_quad_i (reverse_quad_i),
    .grid_x_i       (grid_x_i),
    .grid_z_i       (grid_z_i),
    .texel_value_i  (texel_value_i),
    .full_i         (q_full),
    .push_o         (q_push),
    .entry_o        (q_in)
  );

  hbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  hbs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .empty_i        (q_empty),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .height_o       (height_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
